@@ rtl/core/i2p_pkg.sv @@
// Shared types, constants and functions of the infix to postfix converter.
// Holds the control word layout, the step encoding and character classing.
// No dependencies.
package i2p_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_UNMATCHED = 2'd2
	} err_t;

	typedef enum logic [4:0] {
		S_IDLE, S_E0, S_E1, S_E2, S_OP, S_PU0, S_PU1, S_OVF, S_R0, S_R1,
		S_R2, S_R3, S_RPOP, S_UNM, S_X0, S_X1, S_X2, S_X3, S_FIN
	} step_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_CHAR, EM_SPACE, EM_TOP, EM_OVF, EM_UNM
	} emit_t;

	typedef enum logic [2:0] {
		CD_NEXT, CD_ALWAYS, CD_EMPTY, CD_FULL, CD_TOP_LP, CD_NO_POP
	} cond_t;

	typedef struct packed {
		emit_t emit;
		logic pop;
		logic push;
		logic clr;
		cond_t cond;
		step_t target;
		logic fin;
	} ctrl_t;

	typedef struct packed {
		ctrl_t cw;
		logic go;
		logic accept;
	} dp_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic top_lp;
		logic no_pop;
		logic emit_ok;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	function automatic logic [1:0] prec(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd3;
		if (c == CH_LPAREN) p = 2'd0;
		else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
		else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT || c == CH_BANG) p = 2'd2;
		return p;
	endfunction

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_DOT;
	endfunction

	function automatic step_t entry_step(input logic [7:0] c, input logic eoe);
		step_t s;
		if (eoe) s = S_E0;
		else if (is_operand(c)) s = S_OP;
		else if (c == CH_LPAREN) s = S_PU0;
		else if (c == CH_RPAREN) s = S_R0;
		else s = S_X0;
		return s;
	endfunction

endpackage

@@ rtl/core/infix_to_postfix_converter_top.sv @@
// Top level of the infix to postfix converter.
// Depends on i2p_pkg, i2p_seq and i2p_dp.
//
// The input channel takes one expression character per transaction, or an end
// flag that drains the operator stack. The output channel gives postfix
// characters one per transaction; run_last marks the last one caused by an input,
// and an error transaction (char_out zero) reports stack overflow or an
// unmatched closing parenthesis, after which the stack is empty.
// A microcoded sequencer runs each input through a short program of steps, and
// the next input can be accepted once the sequencer is back in idle.
// Each input runs its own step program: an operand is emitted at once, an end
// pops and emits every operator, a left parenthesis is pushed unless the stack is
// full, a closing parenthesis pops and emits down to its match and drops it, and
// any other character pops and emits each operator of equal or higher precedence
// and is then pushed; each popped operator is emitted with a separating space.
// A result is held until the next result or the final step, so run_last can mark
// the last one; held results then pass on to the output register.
// A stalled output holds its transaction; the sequencer waits on any step that
// emits, and on its final step, while a result is held and the output is stalled.
// Reset empties the stack and drops any result not yet delivered.
module infix_to_postfix_converter_top import i2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] char_in,
	input logic end_of_expr,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] char_out,
	output logic run_last,
	output logic [1:0] error_code
);

	dp_ctrl_t ctl;
	dp_status_t st;

	i2p_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.char_in(char_in),
		.end_of_expr(end_of_expr),
		.st(st),
		.in_stall(in_stall),
		.ctl(ctl)
	);

	i2p_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_in),
		.ctl(ctl),
		.out_stall(out_stall),
		.st(st),
		.char_out(char_out),
		.run_last(run_last),
		.error_code(error_code),
		.out_valid(out_valid)
	);

endmodule

@@ rtl/core/i2p_seq.sv @@
// Microcode sequencer: step counter, control store and jump selection.
// Uses i2p_pkg; drives i2p_dp through a control struct.
module i2p_seq import i2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] char_in,
	input logic end_of_expr,
	input dp_status_t st,
	output logic in_stall,
	output dp_ctrl_t ctl
);

	step_t step_q;
	step_t step_nxt;
	ctrl_t cw;
	logic blocked;
	logic go;
	logic taken;
	logic accept;

	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		w = '{emit: EM_NONE, pop: 1'b0, push: 1'b0, clr: 1'b0, cond: CD_NEXT,
			target: S_IDLE, fin: 1'b0};
		case (s)
			S_E0: begin w.cond = CD_EMPTY; w.target = S_FIN; end
			S_E1: begin w.emit = EM_SPACE; end
			S_E2: begin w.emit = EM_TOP; w.pop = 1'b1; w.cond = CD_ALWAYS; w.target = S_E0; end
			S_OP: begin w.emit = EM_CHAR; w.cond = CD_ALWAYS; w.target = S_FIN; end
			S_PU0: begin w.cond = CD_FULL; w.target = S_OVF; end
			S_PU1: begin w.push = 1'b1; w.cond = CD_ALWAYS; w.target = S_FIN; end
			S_OVF: begin
				w.emit = EM_OVF; w.clr = 1'b1; w.cond = CD_ALWAYS; w.target = S_FIN;
			end
			S_R0: begin w.cond = CD_EMPTY; w.target = S_UNM; end
			S_R1: begin w.cond = CD_TOP_LP; w.target = S_RPOP; end
			S_R2: begin w.emit = EM_SPACE; end
			S_R3: begin w.emit = EM_TOP; w.pop = 1'b1; w.cond = CD_ALWAYS; w.target = S_R0; end
			S_RPOP: begin w.pop = 1'b1; w.cond = CD_ALWAYS; w.target = S_FIN; end
			S_UNM: begin
				w.emit = EM_UNM; w.clr = 1'b1; w.cond = CD_ALWAYS; w.target = S_FIN;
			end
			S_X0: begin w.emit = EM_SPACE; end
			S_X1: begin w.cond = CD_NO_POP; w.target = S_PU0; end
			S_X2: begin w.emit = EM_TOP; w.pop = 1'b1; end
			S_X3: begin w.emit = EM_SPACE; w.cond = CD_ALWAYS; w.target = S_X1; end
			S_FIN: begin w.fin = 1'b1; end
			default: begin end
		endcase
		return w;
	endfunction

	always_comb begin
		cw = rom(step_q);
		blocked = (cw.emit != EM_NONE && !st.emit_ok) ||
			(cw.fin && st.pend_valid && !st.out_free);
		go = (step_q != S_IDLE) && !blocked;
		case (cw.cond)
			CD_ALWAYS: taken = 1'b1;
			CD_EMPTY: taken = st.empty;
			CD_FULL: taken = st.full;
			CD_TOP_LP: taken = st.top_lp;
			CD_NO_POP: taken = st.no_pop;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		step_nxt = step_q;
		if (step_q == S_IDLE) begin
			if (accept) step_nxt = entry_step(char_in, end_of_expr);
		end else if (go) begin
			if (cw.fin) step_nxt = S_IDLE;
			else if (taken) step_nxt = cw.target;
			else step_nxt = step_t'(step_q + 5'd1);
		end
	end

	always_comb begin
		in_stall = (step_q != S_IDLE);
		accept = in_valid && !in_stall;
		ctl.cw = cw;
		ctl.go = go;
		ctl.accept = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= S_IDLE;
		else step_q <= step_nxt;
	end

endmodule

@@ rtl/core/i2p_dp.sv @@
// Datapath: operator stack, current character, held result and output register.
// Uses i2p_pkg; steered by the control struct from i2p_seq.
module i2p_dp import i2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [7:0] char_in,
	input dp_ctrl_t ctl,
	input logic out_stall,
	output dp_status_t st,
	output logic [7:0] char_out,
	output logic run_last,
	output logic [1:0] error_code,
	output logic out_valid
);

	logic [7:0] stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [7:0] char_q;
	logic [7:0] pend_char_q;
	err_t pend_err_q;
	logic pend_valid_q;
	logic [7:0] out_char_q;
	logic out_last_q;
	err_t out_err_q;
	logic out_valid_q;

	logic [7:0] top;
	logic [SP_W-1:0] top_idx;
	logic [7:0] em_char;
	err_t em_err;
	logic do_emit;
	logic do_flush;
	logic out_free;

	always_comb begin
		top_idx = SP_W'(count_q - CNT_W'(1));
		top = stack_q[top_idx];
		out_free = !out_valid_q || !out_stall;
		st.empty = (count_q == '0);
		st.full = (count_q == CNT_W'(STACK_DEPTH));
		st.top_lp = (top == CH_LPAREN);
		st.no_pop = st.empty || (prec(char_q) > prec(top));
		st.emit_ok = !pend_valid_q || out_free;
		st.pend_valid = pend_valid_q;
		st.out_free = out_free;
		em_char = 8'd0;
		em_err = ERR_NONE;
		case (ctl.cw.emit)
			EM_CHAR: em_char = char_q;
			EM_SPACE: em_char = CH_SPACE;
			EM_TOP: em_char = top;
			EM_OVF: em_err = ERR_OVERFLOW;
			EM_UNM: em_err = ERR_UNMATCHED;
			default: em_char = 8'd0;
		endcase
		do_emit = ctl.go && (ctl.cw.emit != EM_NONE);
		do_flush = ctl.go && ctl.cw.fin && pend_valid_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) char_q <= char_in;
		if (ctl.go && ctl.cw.push) stack_q[count_q[SP_W-1:0]] <= char_q;
		if (do_emit) begin
			pend_char_q <= em_char;
			pend_err_q <= em_err;
		end
		if ((do_emit && pend_valid_q) || do_flush) begin
			out_char_q <= pend_char_q;
			out_err_q <= pend_err_q;
			out_last_q <= do_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.go) begin
				if (ctl.cw.clr) count_q <= '0;
				else if (ctl.cw.push) count_q <= count_q + CNT_W'(1);
				else if (ctl.cw.pop) count_q <= count_q - CNT_W'(1);
			end
			if (do_emit) pend_valid_q <= 1'b1;
			else if (do_flush) pend_valid_q <= 1'b0;
			if ((do_emit && pend_valid_q) || do_flush) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign char_out = out_char_q;
	assign run_last = out_last_q;
	assign error_code = out_err_q;
	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/i2p_checker.sv @@
// Port-level checks of the infix to postfix converter top level.
// Bound to infix_to_postfix_converter_top; uses i2p_pkg for the error codes.
module i2p_checker import i2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] char_in,
	input logic end_of_expr,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] char_out,
	input logic run_last,
	input logic [1:0] error_code
);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> run_last && char_out == 8'd0)
		else $error("Error transaction is not a final zero character.");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_UNMATCHED)
		else $error("Undefined error code.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input taken while the previous one was still in work.");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_in) && $stable(end_of_expr))
		else $error("Stalled input transaction changed.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_out) &&
		$stable(run_last) && $stable(error_code))
		else $error("Stalled output transaction changed.");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (.*);

@@ dv/i2p_postfix_check.sv @@
// Checker of the infix to postfix converter: watches both channels, predicts
// the postfix stream with its own operator stack and compares each output.
// Depends on i2p_pkg for the stack depth, character constants and error codes.
module i2p_postfix_check import i2p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] char_in,
	input logic end_of_expr,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] char_out,
	input logic run_last,
	input logic [1:0] error_code,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [7:0] ch;
		logic last;
		err_t err;
	} postfix_t;

	postfix_t postfix_q[$];
	postfix_t want;
	logic [7:0] op_stack [STACK_DEPTH];
	int unsigned op_depth;

	function automatic logic [1:0] bind_rank(input logic [7:0] c);
		if (c == CH_LPAREN) return 2'd0;
		if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
		if (c == CH_STAR || c == CH_SLASH || c == CH_PCT || c == CH_BANG) return 2'd2;
		return 2'd3;
	endfunction

	function automatic logic passes_through(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			(c >= "0" && c <= "9") || c == CH_DOT;
	endfunction

	function automatic void emit_char(input logic [7:0] c, input err_t e);
		postfix_q.push_back('{ch: c, last: 1'b0, err: e});
	endfunction

	function automatic void push_op(input logic [7:0] c);
		if (op_depth >= STACK_DEPTH) begin
			op_depth = 0;
			emit_char(8'h00, ERR_OVERFLOW);
		end else begin
			op_stack[op_depth] = c;
			op_depth++;
		end
	endfunction

	function automatic void convert(input logic [7:0] c, input logic eoe);
		int unsigned first_new;
		logic [7:0] top_op;
		logic found;
		first_new = postfix_q.size();
		if (eoe) begin
			while (op_depth > 0) begin
				op_depth--;
				emit_char(CH_SPACE, ERR_NONE);
				emit_char(op_stack[op_depth], ERR_NONE);
			end
		end else if (passes_through(c)) begin
			emit_char(c, ERR_NONE);
		end else if (c == CH_LPAREN) begin
			push_op(c);
		end else if (c == CH_RPAREN) begin
			found = 1'b0;
			while (!found && op_depth > 0) begin
				op_depth--;
				top_op = op_stack[op_depth];
				if (top_op == CH_LPAREN) begin
					found = 1'b1;
				end else begin
					emit_char(CH_SPACE, ERR_NONE);
					emit_char(top_op, ERR_NONE);
				end
			end
			if (!found) begin
				op_depth = 0;
				emit_char(8'h00, ERR_UNMATCHED);
			end
		end else begin
			emit_char(CH_SPACE, ERR_NONE);
			while (op_depth > 0 && bind_rank(c) <= bind_rank(op_stack[op_depth - 1])) begin
				op_depth--;
				emit_char(op_stack[op_depth], ERR_NONE);
				emit_char(CH_SPACE, ERR_NONE);
			end
			push_op(c);
		end
		if (postfix_q.size() > first_new)
			postfix_q[postfix_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			postfix_q.delete();
			op_depth = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (postfix_q.size() == 0) begin
					$error("unexpected output transaction, char_out %0h", char_out);
					fail_count++;
				end else begin
					want = postfix_q.pop_front();
					if (char_out !== want.ch) begin
						$error("char_out expected %0h got %0h", want.ch, char_out);
						fail_count++;
					end
					if (run_last !== want.last) begin
						$error("run_last expected %0d got %0d", want.last, run_last);
						fail_count++;
					end
					if (error_code !== want.err) begin
						$error("error_code expected %0d got %0d", want.err, error_code);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				convert(char_in, end_of_expr);
			pending = postfix_q.size();
		end
	end

endmodule

@@ dv/infix_to_postfix_converter_top_tb.sv @@
// Testbench top of the infix to postfix converter: drives expressions with
// random gaps and output stalls, and gives the verdict from the checker.
// Depends on i2p_pkg, infix_to_postfix_converter_top and i2p_postfix_check.
module infix_to_postfix_converter_top_tb import i2p_pkg::*;;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned ITEM_TARGET = 320;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] char_in = 8'h00;
	logic end_of_expr = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] char_out;
	logic run_last;
	logic [1:0] error_code;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned stall_roll;
	logic steady = 1'b0;
	logic rx_calm = 1'b0;
	logic [8:0] token_q[$];

	always #5 clk = ~clk;

	infix_to_postfix_converter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_expr(end_of_expr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.run_last(run_last),
		.error_code(error_code)
	);

	i2p_postfix_check postfix_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_expr(end_of_expr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.run_last(run_last),
		.error_code(error_code),
		.fail_count(mismatches),
		.pending(outstanding)
	);

	// The receiver alternates free-running stretches with short and occasional long stalls.
	always @(posedge clk) begin
		if (!arst_n || rx_calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 45) begin
				out_stall <= 1'b0;
				stall_left <= $urandom_range(0, 15);
			end else if (stall_roll < 90) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [7:0] pick_operator();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = CH_PLUS;
			1: c = CH_MINUS;
			2: c = CH_STAR;
			3: c = CH_SLASH;
			4: c = CH_PCT;
			5: c = CH_BANG;
			default: begin
				do c = 8'($urandom_range(0, 255));
				while (is_operand(c) || c == CH_LPAREN || c == CH_RPAREN);
			end
		endcase
		return c;
	endfunction

	function automatic void add_operand();
		logic [7:0] c;
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 3))
				0: c = 8'("A" + $urandom_range(0, 25));
				1: c = 8'("a" + $urandom_range(0, 25));
				2: c = 8'("0" + $urandom_range(0, 9));
				default: c = CH_DOT;
			endcase
			token_q.push_back({1'b0, c});
		end
	endfunction

	function automatic void add_term(input int unsigned lvl);
		if (lvl > 0 && $urandom_range(0, 3) == 0) begin
			token_q.push_back({1'b0, CH_LPAREN});
			add_expr(lvl - 1);
			token_q.push_back({1'b0, CH_RPAREN});
		end else begin
			add_operand();
		end
	endfunction

	function automatic void add_expr(input int unsigned lvl);
		add_term(lvl);
		repeat ($urandom_range(0, 4)) begin
			token_q.push_back({1'b0, pick_operator()});
			add_term(lvl);
		end
	endfunction

	task automatic send_item(input logic [7:0] ch, input logic eoe);
		int unsigned gap;
		logic taken;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		end_of_expr <= eoe;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		int unsigned expr_no;
		int unsigned roll;
		int unsigned nest;
		logic [8:0] directed[$];
		directed = '{
			{1'b0, 8'("A")}, {1'b0, CH_PLUS}, {1'b0, 8'("z")}, {1'b0, CH_STAR},
			{1'b0, CH_LPAREN}, {1'b0, 8'("0")}, {1'b0, CH_MINUS}, {1'b0, 8'("9")},
			{1'b0, CH_RPAREN}, {1'b0, CH_SLASH}, {1'b0, CH_DOT}, {1'b0, CH_PCT},
			{1'b0, 8'("b")}, {1'b0, CH_BANG}, {1'b0, 8'h00}, {1'b0, 8'hFF},
			{1'b0, CH_SPACE}, {1'b1, 8'h00}, {1'b0, CH_RPAREN}, {1'b0, CH_MINUS},
			{1'b0, CH_RPAREN}, {1'b0, CH_LPAREN}, {1'b0, CH_LPAREN}, {1'b1, 8'hFF},
			{1'b1, 8'h5A}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i][7:0], directed[i][8]);

		expr_no = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 5) == 0);
			rx_calm <= ($urandom_range(0, 7) == 0);
			token_q.delete();
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				add_expr($urandom_range(0, 3));
				token_q.push_back({1'b1, 8'($urandom_range(0, 255))});
			end else if (roll < 80) begin
				nest = $urandom_range(12, 20);
				repeat (nest) token_q.push_back({1'b0, CH_LPAREN});
				add_operand();
				token_q.push_back({1'b0, pick_operator()});
				add_operand();
				repeat ($urandom_range(nest - 2, nest + 1))
					token_q.push_back({1'b0, CH_RPAREN});
				token_q.push_back({1'b1, 8'($urandom_range(0, 255))});
			end else begin
				repeat ($urandom_range(1, 10))
					token_q.push_back({($urandom_range(0, 7) == 0),
						8'($urandom_range(0, 255))});
			end
			foreach (token_q[i])
				send_item(token_q[i][7:0], token_q[i][8]);
			if (expr_no == 12)
				wait_drained();
			expr_no++;
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/i2p_pkg.sv
rtl/core/i2p_seq.sv
rtl/core/i2p_dp.sv
rtl/core/infix_to_postfix_converter_top.sv
rtl/core/i2p_checker.sv
dv/i2p_postfix_check.sv
dv/infix_to_postfix_converter_top_tb.sv
